### rtl/core/mfde_pkg.sv
// ----------------------------------------------------------------------------
// mfde_pkg
// shared constants and controller/datapath interface types for the
// monochrome frame store draw engine
// ----------------------------------------------------------------------------
package mfde_pkg;

  localparam int COLUMNS     = 128;
  localparam int ROWS        = 64;
  localparam int PAGES       = 8;
  localparam int STORE_BYTES = PAGES * COLUMNS;
  localparam int ADDR_W      = $clog2(STORE_BYTES);
  localparam int FRAC_BITS   = 10;
  localparam int COORD_W     = 12;
  localparam int DIV_STEPS   = 20;
  localparam int DIV_CNT_W   = $clog2(DIV_STEPS + 1);

  localparam logic [2:0] KIND_PIXEL  = 3'd0;
  localparam logic [2:0] KIND_LINE   = 3'd1;
  localparam logic [2:0] KIND_RECT   = 3'd2;
  localparam logic [2:0] KIND_CIRCLE = 3'd3;
  localparam logic [2:0] KIND_SCROLL = 3'd4;
  localparam logic [2:0] KIND_CLEAR  = 3'd5;
  localparam logic [2:0] KIND_READ   = 3'd6;

  typedef enum logic [3:0] {
    DP_NOP,
    DP_WIPE,
    DP_LOAD,
    DP_LN_SETUP,
    DP_DIV,
    DP_LN_START,
    DP_PLOT_RD,
    DP_PLOT_WR,
    DP_LN_WR,
    DP_CI_ADV,
    DP_SC_HI,
    DP_SC_LO,
    DP_SC_WR,
    DP_RD_BYTE
  } dp_op_t;

  typedef enum logic [1:0] {
    PT_CMD,
    PT_LINE,
    PT_CIRC
  } pt_sel_t;

  typedef struct packed {
    dp_op_t     op;
    pt_sel_t    pt_sel;
    logic [1:0] seg;
    logic [2:0] oct;
  } dp_cmd_t;

  typedef struct packed {
    logic       sweep_last;
    logic       div_last;
    logic       line_last;
    logic       circ_more;
    logic [2:0] kind;
    logic [7:0] rd_data;
  } dp_sts_t;

endpackage

### rtl/core/mfde_datapath.sv
// ----------------------------------------------------------------------------
// mfde_datapath
// frame store memory, command registers, line divider and stepper,
// circle stepper, scroll and clear sweeps
// ----------------------------------------------------------------------------
module mfde_datapath (
  input  logic                clk,
  input  logic                rst_n,
  input  mfde_pkg::dp_cmd_t   cmd,
  output mfde_pkg::dp_sts_t   sts,
  input  logic [2:0]          in_kind,
  input  logic signed [9:0]   in_x_start,
  input  logic signed [9:0]   in_y_start,
  input  logic signed [9:0]   in_x_end,
  input  logic signed [9:0]   in_y_end,
  input  logic [7:0]          in_radius,
  input  logic [3:0]          in_scroll_bits,
  input  logic                in_ink,
  input  logic [9:0]          in_byte_address
);
  import mfde_pkg::*;

  logic [7:0] mem [STORE_BYTES];
  logic [7:0] mem_q_r;

  logic [2:0]        kind_r;
  logic signed [9:0] xs_r, ys_r, xe_r, ye_r;
  logic [3:0]        sbits_r;
  logic              ink_r;
  logic [9:0]        baddr_r;
  logic [ADDR_W-1:0] sweep_r;
  logic [7:0]        hi_r;

  // line state
  logic signed [9:0]         lx0_r, ly0_r;
  logic                      along_y_r, step_neg_r, slope_neg_r;
  logic [9:0]                cnt_r;
  logic signed [COORD_W-1:0] i_r;
  logic signed [20:0]        acc_r;
  logic signed [11:0]        slope_r;
  logic [19:0]               div_q_r;
  logic [9:0]                div_rem_r;
  logic [9:0]                div_den_r;
  logic [DIV_CNT_W-1:0]      div_cnt_r;

  // circle state
  logic signed [COORD_W-1:0] cxv_r, cyv_r;
  logic signed [13:0]        dl_r;

  // plot pipeline
  logic [ADDR_W-1:0] pl_addr_r;
  logic [7:0]        pl_mask_r;
  logic              pl_hit_r;

  logic signed [9:0]  sx0, sy0, sx1, sy1;
  logic signed [10:0] ddx, ddy, ddx_neg, ddy_neg;
  logic [9:0]         adx, ady, span_abs, short_abs;
  logic               along_y, span_neg, short_neg;
  logic [10:0]        div_rs;
  logic               div_ge;
  logic signed [11:0] slope_mag;
  logic signed [10:0] off;
  logic signed [COORD_W-1:0] px, py;
  logic               in_view;
  logic [ADDR_W+COORD_W-1:0] addr_wide;
  logic               pt_hit;
  logic signed [13:0] err;
  logic [15:0]        sc_word;
  logic               rd_en, wr_en;
  logic [ADDR_W-1:0]  rd_addr, wr_addr;
  logic [7:0]         wr_data;
  logic [7:0]         pl_new;

  // segment endpoints
  always_comb begin
    unique case (cmd.seg)
      2'd0: begin sx0 = xs_r; sy0 = ys_r; sx1 = xe_r; sy1 = ys_r; end
      2'd1: begin sx0 = xs_r; sy0 = ye_r; sx1 = xe_r; sy1 = ye_r; end
      2'd2: begin sx0 = xs_r; sy0 = ys_r; sx1 = xs_r; sy1 = ye_r; end
      default: begin sx0 = xe_r; sy0 = ys_r; sx1 = xe_r; sy1 = ye_r; end
    endcase
    if (kind_r == KIND_LINE) begin
      sx0 = xs_r; sy0 = ys_r; sx1 = xe_r; sy1 = ye_r;
    end
  end

  assign ddx       = 11'(sx1) - 11'(sx0);
  assign ddy       = 11'(sy1) - 11'(sy0);
  assign ddx_neg   = -ddx;
  assign ddy_neg   = -ddy;
  assign adx       = ddx[10] ? ddx_neg[9:0] : ddx[9:0];
  assign ady       = ddy[10] ? ddy_neg[9:0] : ddy[9:0];
  assign along_y   = ady > adx;
  assign span_abs  = along_y ? ady : adx;
  assign short_abs = along_y ? adx : ady;
  assign span_neg  = along_y ? ddy[10] : ddx[10];
  assign short_neg = along_y ? ddx[10] : ddy[10];

  // restoring divider step
  assign div_rs = {div_rem_r, div_q_r[19]};
  assign div_ge = div_rs >= {1'b0, div_den_r};

  assign slope_mag = {1'b0, div_q_r[10:0]};

  // current point
  assign off = acc_r[20:FRAC_BITS];
  always_comb begin
    px = COORD_W'(xs_r);
    py = COORD_W'(ys_r);
    unique case (cmd.pt_sel)
      PT_LINE: begin
        if (along_y_r) begin
          px = COORD_W'(lx0_r) + COORD_W'(off);
          py = COORD_W'(ly0_r) + i_r;
        end else begin
          px = COORD_W'(lx0_r) + i_r;
          py = COORD_W'(ly0_r) + COORD_W'(off);
        end
      end
      PT_CIRC: begin
        unique case (cmd.oct)
          3'd0: begin px = COORD_W'(xs_r) + cxv_r; py = COORD_W'(ys_r) + cyv_r; end
          3'd1: begin px = COORD_W'(xs_r) + cxv_r; py = COORD_W'(ys_r) - cyv_r; end
          3'd2: begin px = COORD_W'(xs_r) - cxv_r; py = COORD_W'(ys_r) + cyv_r; end
          3'd3: begin px = COORD_W'(xs_r) - cxv_r; py = COORD_W'(ys_r) - cyv_r; end
          3'd4: begin px = COORD_W'(xs_r) + cyv_r; py = COORD_W'(ys_r) + cxv_r; end
          3'd5: begin px = COORD_W'(xs_r) + cyv_r; py = COORD_W'(ys_r) - cxv_r; end
          3'd6: begin px = COORD_W'(xs_r) - cyv_r; py = COORD_W'(ys_r) + cxv_r; end
          default: begin px = COORD_W'(xs_r) - cyv_r; py = COORD_W'(ys_r) - cxv_r; end
        endcase
      end
      default: begin
        px = COORD_W'(xs_r);
        py = COORD_W'(ys_r);
      end
    endcase
  end

  assign in_view = !px[COORD_W-1] && !py[COORD_W-1] &&
                   (px < COORD_W'(COLUMNS)) && (py < COORD_W'(ROWS));
  assign addr_wide = (ADDR_W+COORD_W)'(py[COORD_W-1:3]) * (ADDR_W+COORD_W)'(COLUMNS)
                   + (ADDR_W+COORD_W)'(px[COORD_W-2:0]);
  assign pt_hit = in_view && (addr_wide < (ADDR_W+COORD_W)'(STORE_BYTES));

  assign err     = ((dl_r + 14'(cyv_r)) <<< 1) - 14'sd1;
  assign sc_word = {hi_r, mem_q_r} >> sbits_r;
  assign pl_new  = ink_r ? (mem_q_r | pl_mask_r) : (mem_q_r & ~pl_mask_r);

  // memory port control
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = sweep_r;
    wr_en   = 1'b0;
    wr_addr = sweep_r;
    wr_data = '0;
    unique case (cmd.op)
      DP_WIPE: wr_en = 1'b1;
      DP_PLOT_RD: begin
        rd_en   = 1'b1;
        rd_addr = addr_wide[ADDR_W-1:0];
      end
      DP_PLOT_WR, DP_LN_WR: begin
        wr_en   = pl_hit_r;
        wr_addr = pl_addr_r;
        wr_data = pl_new;
      end
      DP_SC_HI: begin
        rd_en   = 1'b1;
        rd_addr = sweep_r - ADDR_W'(COLUMNS);
      end
      DP_SC_LO: rd_en = 1'b1;
      DP_SC_WR: begin
        wr_en   = 1'b1;
        wr_data = sc_word[7:0];
      end
      DP_RD_BYTE: begin
        rd_en   = 1'b1;
        rd_addr = baddr_r[ADDR_W-1:0];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      mem_q_r <= mem[rd_addr];
    end
  end

  // sweep counter, set by reset to the last address so the wipe pass starts there and counts down
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sweep_r <= ADDR_W'(STORE_BYTES - 1);
    end else begin
      unique case (cmd.op)
        DP_LOAD:                 sweep_r <= ADDR_W'(STORE_BYTES - 1);
        DP_WIPE, DP_SC_WR:       sweep_r <= sweep_r - 1'b1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      DP_LOAD: begin
        kind_r  <= in_kind;
        xs_r    <= in_x_start;
        ys_r    <= in_y_start;
        xe_r    <= in_x_end;
        ye_r    <= in_y_end;
        sbits_r <= in_scroll_bits;
        ink_r   <= in_ink;
        baddr_r <= in_byte_address;
        cxv_r   <= '0;
        cyv_r   <= COORD_W'(in_radius);
        dl_r    <= 14'sd1 - (14'(in_radius) <<< 1);
      end
      DP_LN_SETUP: begin
        lx0_r       <= sx0;
        ly0_r       <= sy0;
        along_y_r   <= along_y;
        step_neg_r  <= span_neg;
        slope_neg_r <= short_neg ^ span_neg;
        cnt_r       <= span_abs;
        div_q_r     <= {short_abs, 10'b0};
        div_rem_r   <= '0;
        div_den_r   <= span_abs;
        div_cnt_r   <= DIV_CNT_W'(DIV_STEPS);
      end
      DP_DIV: begin
        div_rem_r <= div_ge ? 10'(div_rs - {1'b0, div_den_r}) : div_rs[9:0];
        div_q_r   <= {div_q_r[18:0], div_ge};
        div_cnt_r <= div_cnt_r - 1'b1;
      end
      DP_LN_START: begin
        // zero-length line keeps a zero slope and draws its start point
        if (div_den_r == '0) begin
          slope_r <= '0;
        end else begin
          slope_r <= slope_neg_r ? -slope_mag : slope_mag;
        end
        acc_r <= '0;
        i_r   <= '0;
      end
      DP_PLOT_RD: begin
        pl_addr_r <= addr_wide[ADDR_W-1:0];
        pl_mask_r <= 8'h80 >> py[2:0];
        pl_hit_r  <= pt_hit;
      end
      DP_LN_WR: begin
        i_r   <= step_neg_r ? i_r - 1'b1 : i_r + 1'b1;
        acc_r <= step_neg_r ? acc_r - 21'(slope_r) : acc_r + 21'(slope_r);
        cnt_r <= cnt_r - 1'b1;
      end
      DP_CI_ADV: begin
        if (dl_r < 0 && err <= 0) begin
          cxv_r <= cxv_r + 1'b1;
          dl_r  <= dl_r + (14'(cxv_r) <<< 1) + 14'sd3;
        end else if (dl_r > 0 && err > 0) begin
          cyv_r <= cyv_r - 1'b1;
          dl_r  <= dl_r - (14'(cyv_r) <<< 1) + 14'sd1;
        end else begin
          cxv_r <= cxv_r + 1'b1;
          cyv_r <= cyv_r - 1'b1;
          dl_r  <= dl_r + ((14'(cxv_r) - 14'(cyv_r)) <<< 1) + 14'sd4;
        end
      end
      DP_SC_LO: hi_r <= (sweep_r < ADDR_W'(COLUMNS)) ? 8'h00 : mem_q_r;
      default: ;
    endcase
  end

  always_comb begin
    sts.sweep_last = sweep_r == '0;
    sts.div_last   = div_cnt_r == DIV_CNT_W'(1);
    sts.line_last  = cnt_r == '0;
    sts.circ_more  = cyv_r >= cxv_r;
    sts.kind       = kind_r;
    sts.rd_data    = (kind_r == KIND_READ && {1'b0, baddr_r} < 11'(STORE_BYTES))
                     ? mem_q_r : 8'h00;
  end

endmodule

### rtl/core/mfde_ctrl.sv
// ----------------------------------------------------------------------------
// mfde_ctrl
// command sequencer: steps the datapath through each command and holds
// the result register
// ----------------------------------------------------------------------------
module mfde_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [2:0]        in_kind,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [2:0]        out_done_kind,
  output logic [7:0]        out_read_data,
  output mfde_pkg::dp_cmd_t cmd,
  input  mfde_pkg::dp_sts_t sts
);
  import mfde_pkg::*;

  typedef enum logic [4:0] {
    S_WIPE, S_IDLE, S_PX_RD, S_PX_WR, S_LN_SETUP, S_DIV, S_LN_START,
    S_LN_RD, S_LN_WR, S_CI_CHK, S_CI_RD, S_CI_WR, S_CI_ADV,
    S_SC_HI, S_SC_LO, S_SC_WR, S_CLEAR, S_RB, S_FIN
  } state_t;

  state_t     state_r, state_nxt;
  logic [1:0] seg_r, seg_nxt;
  logic [2:0] oct_r, oct_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic [2:0] out_kind_r, out_kind_nxt;
  logic [7:0] out_data_r, out_data_nxt;

  assign in_stall      = state_r != S_IDLE;
  assign out_valid     = out_valid_r;
  assign out_done_kind = out_kind_r;
  assign out_read_data = out_data_r;

  always_comb begin
    state_nxt     = state_r;
    seg_nxt       = seg_r;
    oct_nxt       = oct_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_kind_nxt  = out_kind_r;
    out_data_nxt  = out_data_r;
    cmd.op        = DP_NOP;
    cmd.pt_sel    = PT_CMD;
    cmd.seg       = seg_r;
    cmd.oct       = oct_r;
    unique case (state_r)
      S_WIPE: begin
        cmd.op = DP_WIPE;
        if (sts.sweep_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.op  = DP_LOAD;
          seg_nxt = 2'd0;
          oct_nxt = 3'd0;
          unique case (in_kind)
            KIND_PIXEL:  state_nxt = S_PX_RD;
            KIND_LINE,
            KIND_RECT:   state_nxt = S_LN_SETUP;
            KIND_CIRCLE: state_nxt = S_CI_CHK;
            KIND_SCROLL: state_nxt = S_SC_HI;
            KIND_CLEAR:  state_nxt = S_CLEAR;
            KIND_READ:   state_nxt = S_RB;
            default:     state_nxt = S_FIN;
          endcase
        end
      end
      S_PX_RD: begin
        cmd.op    = DP_PLOT_RD;
        state_nxt = S_PX_WR;
      end
      S_PX_WR: begin
        cmd.op    = DP_PLOT_WR;
        state_nxt = S_FIN;
      end
      S_LN_SETUP: begin
        cmd.op    = DP_LN_SETUP;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        cmd.op = DP_DIV;
        if (sts.div_last) state_nxt = S_LN_START;
      end
      S_LN_START: begin
        cmd.op    = DP_LN_START;
        state_nxt = S_LN_RD;
      end
      S_LN_RD: begin
        cmd.op     = DP_PLOT_RD;
        cmd.pt_sel = PT_LINE;
        state_nxt  = S_LN_WR;
      end
      S_LN_WR: begin
        cmd.op = DP_LN_WR;
        priority if (!sts.line_last) begin
          state_nxt = S_LN_RD;
        end else if (sts.kind == KIND_RECT && seg_r != 2'd3) begin
          seg_nxt   = seg_r + 1'b1;
          state_nxt = S_LN_SETUP;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_CI_CHK: begin
        oct_nxt   = 3'd0;
        state_nxt = sts.circ_more ? S_CI_RD : S_FIN;
      end
      S_CI_RD: begin
        cmd.op     = DP_PLOT_RD;
        cmd.pt_sel = PT_CIRC;
        state_nxt  = S_CI_WR;
      end
      S_CI_WR: begin
        cmd.op  = DP_PLOT_WR;
        oct_nxt = oct_r + 1'b1;
        state_nxt = (oct_r == 3'd7) ? S_CI_ADV : S_CI_RD;
      end
      S_CI_ADV: begin
        cmd.op    = DP_CI_ADV;
        state_nxt = S_CI_CHK;
      end
      S_SC_HI: begin
        cmd.op    = DP_SC_HI;
        state_nxt = S_SC_LO;
      end
      S_SC_LO: begin
        cmd.op    = DP_SC_LO;
        state_nxt = S_SC_WR;
      end
      S_SC_WR: begin
        cmd.op    = DP_SC_WR;
        state_nxt = sts.sweep_last ? S_FIN : S_SC_HI;
      end
      S_CLEAR: begin
        cmd.op = DP_WIPE;
        if (sts.sweep_last) state_nxt = S_FIN;
      end
      S_RB: begin
        cmd.op    = DP_RD_BYTE;
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = sts.kind;
          out_data_nxt  = sts.rd_data;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_WIPE;
      seg_r       <= '0;
      oct_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      seg_r       <= seg_nxt;
      oct_r       <= oct_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_kind_r <= out_kind_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

### rtl/core/monochrome_framebuffer_draw_engine_unit.sv
// ----------------------------------------------------------------------------
// monochrome_framebuffer_draw_engine_unit
// 128x64 one-bit page-organized frame store with pixel, line, rectangle,
// circle, scroll, clear and byte read commands
// ----------------------------------------------------------------------------
// one command beat in, one result beat out per command. all store traffic
// goes through a single-port 1024x8 memory, one access per cycle, so the
// cost of a command is its count of memory accesses: a pixel a read and a
// write, a byte read one read, a clear a write per byte, a scroll two reads
// and a write per byte, a line a setup pass through the bit-serial slope
// divider plus a read and a write per pixel, a rectangle four such lines,
// and a circle 8 mirrored read-modify-writes per step of the midpoint loop.
// after reset the block zeroes the store with in_stall high. a result waits
// in the output register while the next command beat may already be taken
// ----------------------------------------------------------------------------
module monochrome_framebuffer_draw_engine_unit (
  input  logic              clk,
  input  logic              rst_n,
  // command channel
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [2:0]        in_kind,
  input  logic signed [9:0] in_x_start,
  input  logic signed [9:0] in_y_start,
  input  logic signed [9:0] in_x_end,
  input  logic signed [9:0] in_y_end,
  input  logic [7:0]        in_radius,
  input  logic [3:0]        in_scroll_bits,
  input  logic              in_ink,
  input  logic [9:0]        in_byte_address,
  // result channel
  output logic              out_valid,
  input  logic              out_stall,
  output logic [2:0]        out_done_kind,
  output logic [7:0]        out_read_data
);
  import mfde_pkg::*;

  // sequencer commands and datapath status
  dp_cmd_t cmd;
  dp_sts_t sts;

  // state machine, result register
  mfde_ctrl u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_kind       (in_kind),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_done_kind (out_done_kind),
    .out_read_data (out_read_data),
    .cmd           (cmd),
    .sts           (sts)
  );

  // frame store and the arithmetic of each drawing command
  mfde_datapath u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_kind         (in_kind),
    .in_x_start      (in_x_start),
    .in_y_start      (in_y_start),
    .in_x_end        (in_x_end),
    .in_y_end        (in_y_end),
    .in_radius       (in_radius),
    .in_scroll_bits  (in_scroll_bits),
    .in_ink          (in_ink),
    .in_byte_address (in_byte_address)
  );

`ifndef ASSERT_OFF
  // one command in flight: the beat after acceptance must see the block busy
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("command accepted while previous one still busy");

  // only a byte read carries data back
  a_data_only_on_read: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_done_kind != KIND_READ |-> out_read_data == 8'h00)
    else $error("nonzero read data on a non-read result");
`endif

endmodule

### dv/mfde_draw_checker.sv
// ----------------------------------------------------------------------------
// mfde_draw_checker
// watches the command and result channels of the draw engine, keeps its own
// copy of the frame store, predicts each result beat and compares it
// ----------------------------------------------------------------------------
module mfde_draw_checker (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_stall,
  input  logic [2:0]        in_kind,
  input  logic signed [9:0] in_x_start,
  input  logic signed [9:0] in_y_start,
  input  logic signed [9:0] in_x_end,
  input  logic signed [9:0] in_y_end,
  input  logic [7:0]        in_radius,
  input  logic [3:0]        in_scroll_bits,
  input  logic              in_ink,
  input  logic [9:0]        in_byte_address,
  input  logic              out_valid,
  input  logic              out_stall,
  input  logic [2:0]        out_done_kind,
  input  logic [7:0]        out_read_data,
  output int                mismatch_count,
  output int                results_pending
);
  import mfde_pkg::*;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] data;
  } done_beat_t;

  logic [7:0] shadow_store [0:STORE_BYTES-1];
  done_beat_t done_q [$];

  initial begin
    foreach (shadow_store[a]) shadow_store[a] = 8'h00;
    mismatch_count  = 0;
    results_pending = 0;
  end

  function automatic int mag(input int v);
    return (v < 0) ? -v : v;
  endfunction

  // clipped pixel write
  function automatic void put_pixel(input int x, input int y, input bit ink);
    int a;
    if (x < 0 || y < 0 || x >= COLUMNS || y >= ROWS) return;
    a = (y / 8) * COLUMNS + x;
    if (a >= STORE_BYTES) return;
    if (ink) shadow_store[a] = shadow_store[a] | (8'h80 >> (y % 8));
    else     shadow_store[a] = shadow_store[a] & ~(8'h80 >> (y % 8));
  endfunction

  // fixed-point dda, long axis steps, ties step along x
  function automatic void trace_line(input int x0, input int y0, input int x1,
                                     input int y1, input bit ink);
    int dx, dy, span, slope, dir, off, i;
    bit along_y;
    dx = x1 - x0;
    dy = y1 - y0;
    along_y = mag(dy) > mag(dx);
    span = along_y ? dy : dx;
    if (span == 0) begin
      put_pixel(x0, y0, ink);
      return;
    end
    slope = along_y ? (dx * 1024) / dy : (dy * 1024) / dx;
    dir = (span > 0) ? 1 : -1;
    i = 0;
    for (int k = 0; k <= mag(span); k++) begin
      off = (i * slope) >>> FRAC_BITS;
      if (along_y) put_pixel(x0 + off, y0 + i, ink);
      else         put_pixel(x0 + i, y0 + off, ink);
      i += dir;
    end
  endfunction

  function automatic void trace_circle(input int cx, input int cy, input int r,
                                       input bit ink);
    int x, y, delta, err;
    x = 0;
    y = r;
    delta = 1 - 2 * r;
    while (y >= x) begin
      put_pixel(cx + x, cy + y, ink);
      put_pixel(cx + x, cy - y, ink);
      put_pixel(cx - x, cy + y, ink);
      put_pixel(cx - x, cy - y, ink);
      put_pixel(cx + y, cy + x, ink);
      put_pixel(cx + y, cy - x, ink);
      put_pixel(cx - y, cy + x, ink);
      put_pixel(cx - y, cy - x, ink);
      err = 2 * (delta + y) - 1;
      if (delta < 0 && err <= 0) begin
        x++;
        delta += 2 * x + 1;
      end else if (delta > 0 && err > 0) begin
        y--;
        delta -= 2 * y + 1;
      end else begin
        x++;
        y--;
        delta += 2 * (x - y);
      end
    end
  endfunction

  // pages shift down, bits from the page above enter at the top
  function automatic void shift_pages(input int n);
    logic [31:0] word;
    for (int p = PAGES - 1; p > 0; p--) begin
      for (int c = 0; c < COLUMNS; c++) begin
        word = {16'h0, shadow_store[(p - 1) * COLUMNS + c], shadow_store[p * COLUMNS + c]};
        word = word >> n;
        shadow_store[p * COLUMNS + c] = word[7:0];
      end
    end
    for (int c = 0; c < COLUMNS; c++) shadow_store[c] = shadow_store[c] >> n;
  endfunction

  function automatic done_beat_t run_command(
    input logic [2:0] kind, input int xs, input int ys, input int xe, input int ye,
    input int r, input int n, input bit ink, input int a);
    done_beat_t d;
    d.kind = kind;
    d.data = 8'h00;
    case (kind)
      KIND_PIXEL:  put_pixel(xs, ys, ink);
      KIND_LINE:   trace_line(xs, ys, xe, ye, ink);
      KIND_RECT: begin
        trace_line(xs, ys, xe, ys, ink);
        trace_line(xs, ye, xe, ye, ink);
        trace_line(xs, ys, xs, ye, ink);
        trace_line(xe, ys, xe, ye, ink);
      end
      KIND_CIRCLE: trace_circle(xs, ys, r, ink);
      KIND_SCROLL: shift_pages(n);
      KIND_CLEAR:  foreach (shadow_store[i]) shadow_store[i] = 8'h00;
      KIND_READ:   if (a < STORE_BYTES) d.data = shadow_store[a];
      default: ;
    endcase
    return d;
  endfunction

  always @(posedge clk) begin
    done_beat_t got, want;
    if (rst_n && in_valid && !in_stall)
      done_q.push_back(run_command(in_kind, int'(in_x_start), int'(in_y_start),
                                   int'(in_x_end), int'(in_y_end), int'(in_radius),
                                   int'(in_scroll_bits), in_ink, int'(in_byte_address)));
    if (rst_n && out_valid && !out_stall) begin
      got.kind = out_done_kind;
      got.data = out_read_data;
      if (done_q.size() == 0) begin
        $display("%0t unexpected result beat: expected none, actual kind %0d data %02h",
                 $time, got.kind, got.data);
        mismatch_count++;
      end else begin
        want = done_q.pop_front();
        if (got.kind !== want.kind) begin
          $display("%0t done_kind: expected %0d, actual %0d", $time, want.kind, got.kind);
          mismatch_count++;
        end
        if (got.data !== want.data) begin
          $display("%0t read_data: expected %02h, actual %02h", $time, want.data, got.data);
          mismatch_count++;
        end
      end
    end
    results_pending <= done_q.size();
  end

endmodule

### dv/tb_monochrome_framebuffer_draw_engine_unit.sv
// ----------------------------------------------------------------------------
// tb_monochrome_framebuffer_draw_engine_unit
// drives directed and random draw commands into the engine with random
// idling on both channels; a separate checker predicts and compares results
// ----------------------------------------------------------------------------
module tb_monochrome_framebuffer_draw_engine_unit;
  import mfde_pkg::*;

  localparam logic [2:0] KIND_SPARE = 3'd7;   // unused code, must just echo back
  localparam int RANDOM_CMDS = 270;
  localparam int STALL_LIMIT = 50000;         // cycles with no beat on either side

  typedef struct packed {
    logic [2:0]        kind;
    logic signed [9:0] xs;
    logic signed [9:0] ys;
    logic signed [9:0] xe;
    logic signed [9:0] ye;
    logic [7:0]        radius;
    logic [3:0]        nbits;
    logic              ink;
    logic [9:0]        addr;
  } draw_cmd_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [2:0]        in_kind = '0;
  logic signed [9:0] in_x_start = '0;
  logic signed [9:0] in_y_start = '0;
  logic signed [9:0] in_x_end = '0;
  logic signed [9:0] in_y_end = '0;
  logic [7:0]        in_radius = '0;
  logic [3:0]        in_scroll_bits = '0;
  logic              in_ink = 1'b0;
  logic [9:0]        in_byte_address = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [2:0]        out_done_kind;
  logic [7:0]        out_read_data;

  int mismatch_count;
  int results_pending;
  int cmds_sent = 0;
  int results_taken = 0;
  int idle_cycles = 0;

  always #5 clk = ~clk;

  monochrome_framebuffer_draw_engine_unit dut (.*);

  mfde_draw_checker checker_i (.*);

  // --------------------------------------------------------------------------
  // command side
  // --------------------------------------------------------------------------

  // one command beat: optional gap with valid low, then hold until taken
  task automatic send_cmd(input draw_cmd_t c, input int gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_kind         <= c.kind;
    in_x_start      <= c.xs;
    in_y_start      <= c.ys;
    in_x_end        <= c.xe;
    in_y_end        <= c.ye;
    in_radius       <= c.radius;
    in_scroll_bits  <= c.nbits;
    in_ink          <= c.ink;
    in_byte_address <= c.addr;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    cmds_sent++;
  endtask

  // fills every field at random so unused fields toggle too
  function automatic draw_cmd_t noise_cmd(input logic [2:0] kind);
    draw_cmd_t c;
    c = $bits(draw_cmd_t)'({$urandom(), $urandom(), $urandom()});
    c.kind = kind;
    return c;
  endfunction

  function automatic draw_cmd_t mk_cmd(input logic [2:0] kind, input int xs, input int ys,
                                       input int xe, input int ye, input int r,
                                       input int n, input bit ink, input int a);
    draw_cmd_t c;
    c = noise_cmd(kind);
    c.xs = 10'(xs); c.ys = 10'(ys); c.xe = 10'(xe); c.ye = 10'(ye);
    c.radius = 8'(r); c.nbits = 4'(n); c.ink = ink; c.addr = 10'(a);
    return c;
  endfunction

  // mostly near the visible area, now and then anywhere in the 10-bit range
  function automatic logic signed [9:0] pick_coord(input int span);
    if ($urandom_range(9, 0) == 0) return 10'($urandom());
    return 10'($urandom_range(span + 16, 0) - 16);
  endfunction

  function automatic draw_cmd_t random_cmd();
    draw_cmd_t c;
    int roll;
    roll = $urandom_range(99, 0);
    if      (roll < 20) c = noise_cmd(KIND_PIXEL);
    else if (roll < 38) c = noise_cmd(KIND_LINE);
    else if (roll < 47) c = noise_cmd(KIND_RECT);
    else if (roll < 57) c = noise_cmd(KIND_CIRCLE);
    else if (roll < 92) c = noise_cmd(KIND_READ);
    else if (roll < 96) c = noise_cmd(KIND_SCROLL);
    else if (roll < 98) c = noise_cmd(KIND_CLEAR);
    else                c = noise_cmd(KIND_SPARE);
    c.xs = pick_coord(COLUMNS);
    c.xe = pick_coord(COLUMNS);
    c.ys = pick_coord(ROWS);
    c.ye = pick_coord(ROWS);
    // keep most circles small, a few up to the full radius
    if ($urandom_range(7, 0) != 0) c.radius = 8'($urandom_range(48, 0));
    return c;
  endfunction

  function automatic int sender_gap(input int idx);
    if (idx >= 100 && idx < 140) return 0;   // back-to-back stretch
    return $urandom_range(3, 0);
  endfunction

  initial begin
    draw_cmd_t dir_q [$];

    // corners, off-screen pixels and extreme field values
    dir_q.push_back(mk_cmd(KIND_PIXEL, 0, 0, 0, 0, 0, 0, 1, 0));
    dir_q.push_back(mk_cmd(KIND_PIXEL, 127, 63, 0, 0, 255, 15, 1, 1023));
    dir_q.push_back(mk_cmd(KIND_PIXEL, -1, 5, -512, 511, 0, 0, 1, 0));
    dir_q.push_back(mk_cmd(KIND_PIXEL, 128, 0, 511, -512, 0, 0, 1, 0));
    dir_q.push_back(mk_cmd(KIND_PIXEL, 5, 64, 0, 0, 0, 0, 1, 0));
    dir_q.push_back(mk_cmd(KIND_PIXEL, -512, -512, 0, 0, 0, 0, 1, 0));
    dir_q.push_back(mk_cmd(KIND_PIXEL, 511, 511, 0, 0, 0, 0, 1, 0));
    dir_q.push_back(mk_cmd(KIND_READ, 0, 0, 0, 0, 0, 0, 0, 0));
    dir_q.push_back(mk_cmd(KIND_READ, 0, 0, 0, 0, 0, 0, 0, 1023));
    // zero-length line, shallow, steep, diagonal tie, clipped
    dir_q.push_back(mk_cmd(KIND_LINE, 10, 10, 10, 10, 0, 0, 1, 0));
    dir_q.push_back(mk_cmd(KIND_LINE, 120, 3, 2, 20, 0, 0, 1, 0));
    dir_q.push_back(mk_cmd(KIND_LINE, 40, 60, 47, 1, 0, 0, 1, 0));
    dir_q.push_back(mk_cmd(KIND_LINE, 30, 30, 0, 0, 0, 0, 1, 0));
    dir_q.push_back(mk_cmd(KIND_LINE, -512, -300, 511, 400, 0, 0, 1, 0));
    dir_q.push_back(mk_cmd(KIND_RECT, 5, 50, 90, 12, 0, 0, 1, 0));
    dir_q.push_back(mk_cmd(KIND_CIRCLE, 64, 32, 0, 0, 0, 0, 1, 0));
    dir_q.push_back(mk_cmd(KIND_CIRCLE, 64, 32, 0, 0, 20, 0, 1, 0));
    dir_q.push_back(mk_cmd(KIND_CIRCLE, 64, 32, 0, 0, 255, 0, 1, 0));
    dir_q.push_back(mk_cmd(KIND_PIXEL, 64, 12, 0, 0, 0, 0, 0, 0));
    dir_q.push_back(mk_cmd(KIND_READ, 0, 0, 0, 0, 0, 0, 0, 128 + 64));
    // scroll amounts zero, mid, one page and just under two pages
    dir_q.push_back(mk_cmd(KIND_SCROLL, 0, 0, 0, 0, 0, 0, 0, 0));
    dir_q.push_back(mk_cmd(KIND_SCROLL, 0, 0, 0, 0, 0, 3, 0, 0));
    dir_q.push_back(mk_cmd(KIND_SCROLL, 0, 0, 0, 0, 0, 8, 0, 0));
    dir_q.push_back(mk_cmd(KIND_SPARE, 0, 0, 0, 0, 0, 0, 0, 0));
    dir_q.push_back(mk_cmd(KIND_SCROLL, 0, 0, 0, 0, 0, 15, 0, 0));
    dir_q.push_back(mk_cmd(KIND_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0));

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_q[i]) send_cmd(dir_q[i], $urandom_range(3, 0));

    for (int i = 0; i < RANDOM_CMDS; i++) begin
      // pause with valid low until the engine has drained completely
      if (i == 180) begin
        in_valid <= 1'b0;
        @(posedge clk);
        while (results_pending != 0) @(posedge clk);
      end
      send_cmd(random_cmd(), sender_gap(i));
    end
    in_valid <= 1'b0;

    // drain, then a short settle
    @(posedge clk);
    while (results_pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatch_count == 0 && results_pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // --------------------------------------------------------------------------
  // result side
  // --------------------------------------------------------------------------

  // random hold-off per beat, two long hold-offs so the engine backs up
  initial begin
    int hold;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (results_taken == 40 || results_taken == 210) hold = 3000;
      else if (results_taken >= 100 && results_taken < 140) hold = 0;
      else hold = $urandom_range(3, 0);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      results_taken++;
    end
  end

  // --------------------------------------------------------------------------
  // watchdog: the reset wipe, a scroll and a long hold-off all fit well inside
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("status: fail");
        $finish;
      end
    end
  end

endmodule
